@@ rtl/json_string_unescape_to_utf8_core_macros.svh @@
// assertion macros for the json string unescaper checker
`ifndef JSON_STRING_UNESCAPE_TO_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_TO_UTF8_CORE_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu check failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu check failed");

`endif

@@ rtl/jsu_pkg.sv @@
// shared types, constants and utf-8 helpers for the json string unescaper
package jsu_pkg;

  localparam int CP_W       = 21;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic            valid;
    logic            raw;
    logic [CP_W-1:0] cp;
  } slot_t;

  typedef struct packed {
    slot_t a;
    slot_t b;
    logic  last;
    logic  err;
  } job_t;

  // index of the final byte of a slot's encoding
  function automatic logic [1:0] utf8_lidx(input slot_t s);
    logic [1:0] r;
    begin
      if (s.raw || s.cp < CP_W'(21'h80)) begin
        r = 2'd0;
      end else if (s.cp < CP_W'(21'h800)) begin
        r = 2'd1;
      end else if (s.cp < CP_W'(21'h10000)) begin
        r = 2'd2;
      end else begin
        r = 2'd3;
      end
      return r;
    end
  endfunction

  // byte k of the encoding whose final byte index is lidx
  function automatic logic [7:0] utf8_byte(input slot_t s, input logic [1:0] k,
                                           input logic [1:0] lidx);
    logic [7:0] r;
    logic [1:0] d;
    begin
      d = lidx - k;
      if (lidx == 2'd0) begin
        r = s.cp[7:0];
      end else if (k == 2'd0) begin
        unique case (lidx)
          2'd1:    r = {3'b110, s.cp[10:6]};
          2'd2:    r = {4'b1110, s.cp[15:12]};
          default: r = {5'b11110, s.cp[20:18]};
        endcase
      end else begin
        unique case (d)
          2'd1:    r = {2'b10, s.cp[11:6]};
          2'd2:    r = {2'b10, s.cp[17:12]};
          default: r = {2'b10, s.cp[5:0]};
        endcase
      end
      return r;
    end
  endfunction

endpackage

@@ rtl/jsu_fifo.sv @@
// short job queue between the classifier and the byte emitter
module jsu_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  jsu_pkg::job_t wdata,
  input  logic          rd,
  output jsu_pkg::job_t rdata,
  output logic          full,
  output logic          nempty
);
  import jsu_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full   = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign nempty = (count != '0);
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/jsu_front.sv @@
// escape classifier: tracks escape state and turns words into jobs
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output jsu_pkg::job_t job,
  output logic          job_push
);
  import jsu_pkg::*;

  localparam logic [2:0] M_PLAIN   = 3'd0;
  localparam logic [2:0] M_ESC     = 3'd1;
  localparam logic [2:0] M_HEX1    = 3'd2;
  localparam logic [2:0] M_AHIGH   = 3'd3;
  localparam logic [2:0] M_AHIGHBS = 3'd4;
  localparam logic [2:0] M_HEX2    = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  logic [2:0]  mode;
  logic [1:0]  dcnt;
  logic [15:0] acc;
  logic [15:0] high;
  logic        err;

  logic [2:0]  mode_next;
  logic [1:0]  dcnt_next;
  logic [15:0] acc_next;
  logic [15:0] high_next;
  logic        err_next;

  logic        hex_ok;
  logic [3:0]  nib;
  logic [15:0] acc_sh;
  logic        simp_ok;
  logic [7:0]  simp_val;
  job_t        j;

  function automatic slot_t mk_raw(input logic [7:0] b);
    slot_t s;
    begin
      s.valid = 1'b1;
      s.raw   = 1'b1;
      s.cp    = CP_W'(b);
      return s;
    end
  endfunction

  function automatic slot_t mk_cp(input logic [CP_W-1:0] c);
    slot_t s;
    begin
      s.valid = 1'b1;
      s.raw   = 1'b0;
      s.cp    = c;
      return s;
    end
  endfunction

  function automatic logic is_high(input logic [15:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return u[15:10] == 6'b110111;
  endfunction

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (in_byte >= CH_0 && in_byte <= CH_9) begin
      nib = 4'(in_byte - CH_0);
    end else if (in_byte >= CH_LA && in_byte <= CH_LF) begin
      nib = 4'(in_byte - CH_LA + 8'd10);
    end else if (in_byte >= CH_UA && in_byte <= CH_UF) begin
      nib = 4'(in_byte - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    acc_sh = {acc[11:0], nib};
  end

  always_comb begin
    simp_ok  = 1'b1;
    simp_val = in_byte;
    case (in_byte)
      CH_QUOTE, CH_BSLASH, CH_SLASH: simp_val = in_byte;
      CH_B:    simp_val = 8'h08;
      CH_F:    simp_val = 8'h0C;
      CH_N:    simp_val = 8'h0A;
      CH_R:    simp_val = 8'h0D;
      CH_T:    simp_val = 8'h09;
      default: simp_ok  = 1'b0;
    endcase
  end

  always_comb begin
    mode_next = mode;
    dcnt_next = dcnt;
    acc_next  = acc;
    high_next = high;
    err_next  = err;
    j         = '0;

    if (!err) begin
      unique case (mode)
        M_ESC: begin
          if (in_byte == CH_U) begin
            mode_next = M_HEX1;
            dcnt_next = 2'd0;
            acc_next  = 16'd0;
          end else if (simp_ok) begin
            j.a       = mk_raw(simp_val);
            mode_next = M_PLAIN;
          end else begin
            err_next  = 1'b1;
            mode_next = M_PLAIN;
          end
        end
        M_HEX1: begin
          if (!hex_ok) begin
            err_next  = 1'b1;
            mode_next = M_PLAIN;
          end else begin
            acc_next = acc_sh;
            if (dcnt == 2'd3) begin
              dcnt_next = 2'd0;
              if (is_high(acc_sh)) begin
                high_next = acc_sh;
                mode_next = M_AHIGH;
              end else begin
                j.a       = mk_cp(CP_W'(acc_sh));
                mode_next = M_PLAIN;
              end
            end else begin
              dcnt_next = dcnt + 2'd1;
            end
          end
        end
        M_AHIGH: begin
          if (in_byte == CH_BSLASH) begin
            mode_next = M_AHIGHBS;
          end else begin
            j.a       = mk_cp(CP_W'(high));
            j.b       = mk_raw(in_byte);
            mode_next = M_PLAIN;
          end
        end
        M_AHIGHBS: begin
          if (in_byte == CH_U) begin
            mode_next = M_HEX2;
            dcnt_next = 2'd0;
            acc_next  = 16'd0;
          end else if (simp_ok) begin
            j.a       = mk_cp(CP_W'(high));
            j.b       = mk_raw(simp_val);
            mode_next = M_PLAIN;
          end else begin
            err_next  = 1'b1;
            mode_next = M_PLAIN;
          end
        end
        M_HEX2: begin
          if (!hex_ok) begin
            err_next  = 1'b1;
            mode_next = M_PLAIN;
          end else begin
            acc_next = acc_sh;
            if (dcnt == 2'd3) begin
              dcnt_next = 2'd0;
              if (is_low(acc_sh)) begin
                j.a = mk_cp(CP_W'(21'h10000) + {1'b0, high[9:0], acc_sh[9:0]});
                mode_next = M_PLAIN;
              end else begin
                j.a = mk_cp(CP_W'(high));
                if (is_high(acc_sh)) begin
                  high_next = acc_sh;
                  mode_next = M_AHIGH;
                end else begin
                  j.b       = mk_cp(CP_W'(acc_sh));
                  mode_next = M_PLAIN;
                end
              end
            end else begin
              dcnt_next = dcnt + 2'd1;
            end
          end
        end
        default: begin
          if (in_byte == CH_BSLASH) begin
            mode_next = M_ESC;
          end else begin
            mode_next = M_PLAIN;
            j.a       = mk_raw(in_byte);
          end
        end
      endcase
    end

    if (in_last) begin
      if (!err_next) begin
        if (mode_next == M_AHIGH) begin
          if (!j.a.valid) begin
            j.a = mk_cp(CP_W'(high_next));
          end else begin
            j.b = mk_cp(CP_W'(high_next));
          end
        end else if (mode_next != M_PLAIN) begin
          err_next = 1'b1;
        end
      end
      if (err_next) begin
        j     = '0;
        j.err = 1'b1;
      end
      j.last = 1'b1;
    end
  end

  assign job      = j;
  assign job_push = accept && (j.last || j.a.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_PLAIN;
      dcnt <= 2'd0;
      acc  <= 16'd0;
      high <= 16'd0;
      err  <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        mode <= M_PLAIN;
        dcnt <= 2'd0;
        acc  <= 16'd0;
        high <= 16'd0;
        err  <= 1'b0;
      end else begin
        mode <= mode_next;
        dcnt <= dcnt_next;
        acc  <= acc_next;
        high <= high_next;
        err  <= err_next;
      end
    end
  end

endmodule

@@ rtl/jsu_back.sv @@
// byte emitter: walks each job's slots and drives the result register
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  jsu_pkg::job_t head,
  input  logic          head_valid,
  output logic          head_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          has_byte,
  output logic          bad_escape,
  output logic          out_last
);
  import jsu_pkg::*;

  logic       ov;
  logic       sel;
  logic [1:0] idx;

  slot_t      cur;
  logic [1:0] lidx;
  logic       bare;
  logic       job_end;
  logic       take;
  logic       adv;
  logic [7:0] byte_val;

  always_comb begin
    cur      = sel ? head.b : head.a;
    lidx     = utf8_lidx(cur);
    bare     = !head.a.valid;
    job_end  = bare || ((idx == lidx) && (sel || !head.b.valid));
    byte_val = bare ? 8'd0 : utf8_byte(cur, idx, lidx);
    take     = !ov || pop;
    adv      = take && head_valid;
  end

  assign head_pop = adv && job_end;
  assign empty    = !ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      sel <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (take) begin
        ov <= head_valid;
      end
      if (adv) begin
        if (job_end) begin
          sel <= 1'b0;
          idx <= 2'd0;
        end else if (idx == lidx) begin
          sel <= 1'b1;
          idx <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte   <= byte_val;
      has_byte   <= !bare;
      bad_escape <= bare && head.err;
      out_last   <= job_end && head.last;
    end
  end

endmodule

@@ rtl/json_string_unescape_to_utf8_core.sv @@
// top level of the json string unescaper with utf-8 output
//
//   channel  | handshake          | words
//   ---------+--------------------+--------------------------------------------
//   input    | push / full        | in_byte, in_last
//   result   | pop / empty        | out_byte, has_byte, bad_escape, out_last
//
// one input word is taken per cycle while the 4-entry job queue has room
// the emitter gives one result word per cycle unless stalled; a word of n bytes
//   (at most 6) holds it until all are out, so long escapes fill the queue
// an input word passes the job queue and the result register before the ports
// synchronous reset clears escape state, queue pointers and the result valid
module json_string_unescape_to_utf8_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       bad_escape,
  output logic       out_last
);
  import jsu_pkg::*;

  logic accept;
  job_t fjob;
  logic fpush;
  job_t head;
  logic head_valid;
  logic head_pop;

  assign accept = push && !full;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .job      (fjob),
    .job_push (fpush)
  );

  jsu_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (fpush),
    .wdata  (fjob),
    .rd     (head_pop),
    .rdata  (head),
    .full   (full),
    .nempty (head_valid)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .bad_escape (bad_escape),
    .out_last   (out_last)
  );

endmodule

@@ rtl/jsu_checker.sv @@
// port-level checks for the json string unescaper, bound to the top level
`include "json_string_unescape_to_utf8_core_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       bad_escape,
  input logic       out_last
);

  // error flag only rides on the closing word
  `JSU_ASSERT_NOW(a_bad_on_last, !empty && bad_escape, out_last)

  // error closing word carries no byte
  `JSU_ASSERT_NOW(a_bad_is_bare, !empty && bad_escape, !has_byte)

  // a bare word is always the end marker with a zero byte
  `JSU_ASSERT_NOW(a_bare_marker, !empty && !has_byte, out_last && out_byte == 8'd0)

  // a result not taken stays put
  `JSU_ASSERT_NEXT(a_hold, !empty && !pop,
                   !empty && $stable(out_byte) && $stable(has_byte) && $stable(out_last))

endmodule

bind json_string_unescape_to_utf8_core jsu_checker u_jsu_checker (.*);

@@ verif/json_string_unescape_to_utf8_core_test.sv @@
// self-checking testbench for the json string unescaper with utf-8 output
`timescale 1ns / 100ps

module json_string_unescape_to_utf8_core_test;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  localparam int PHASE_BYTES = 4;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    ST_TEXT, ST_ESC, ST_HEX, ST_HIGH, ST_HIGH_BS, ST_HEX_LOW
  } esc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       bad;
    logic       last;
  } utf8_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       bad_escape;
  logic       out_last;

  esc_state_t esc_state = ST_TEXT;
  logic [1:0]  digits = 2'd0;
  logic [15:0] hex_acc = 16'h0000;
  logic [15:0] held_high = 16'h0000;
  logic        err_flag = 1'b0;

  utf8_word_t step_words[$];
  utf8_word_t expected_words[$];
  raw_word_t  pending_words[$];
  raw_word_t  next_word;
  logic [7:0] build_bytes[$];

  int send_idle = 0;
  int recv_stall = 0;
  int queued_bytes = 0;
  int error_count = 0;

  json_string_unescape_to_utf8_core dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .bad_escape (bad_escape),
    .out_last   (out_last)
  );

  always #2 clk = ~clk;

  function automatic int hex_nibble(input logic [7:0] c);
    int r;
    r = -1;
    if (c >= CH_0 && c <= CH_9) r = int'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LF) r = int'(c - CH_LA) + 10;
    else if (c >= CH_UA && c <= CH_UF) r = int'(c - CH_UA) + 10;
    return r;
  endfunction

  function automatic bit simple_esc(input logic [7:0] c, output logic [7:0] v);
    bit ok;
    ok = 1'b1;
    v = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
      CH_B: v = CTL_BS;
      CH_LF: v = CTL_FF;
      CH_N: v = CTL_LF;
      CH_R: v = CTL_CR;
      CH_T: v = CTL_TAB;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    step_words.push_back({b, 1'b1, 1'b0, 1'b0});
  endtask

  task automatic emit_code(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic fail_escape();
    err_flag = 1'b1;
    esc_state = ST_TEXT;
  endtask

  task automatic take_digit(input logic [7:0] b, output bit done);
    int h;
    h = hex_nibble(b);
    done = 1'b0;
    if (h < 0) begin
      fail_escape();
    end else begin
      hex_acc = {hex_acc[11:0], 4'(h)};
      if (digits == 2'd3) begin
        digits = 2'd0;
        done = 1'b1;
      end else begin
        digits = digits + 2'd1;
      end
    end
  endtask

  task automatic unit_alone(input logic [15:0] u);
    if (u >= 16'hD800 && u <= 16'hDBFF) begin
      held_high = u;
      esc_state = ST_HIGH;
    end else begin
      emit_code({5'b0, u});
      esc_state = ST_TEXT;
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic last);
    logic [7:0] v;
    bit done;
    utf8_word_t w;
    step_words.delete();
    if (!err_flag) begin
      case (esc_state)
        ST_ESC: begin
          if (b == CH_U) begin
            esc_state = ST_HEX;
            digits = 2'd0;
            hex_acc = 16'h0000;
          end else if (simple_esc(b, v)) begin
            emit_byte(v);
            esc_state = ST_TEXT;
          end else begin
            fail_escape();
          end
        end
        ST_HEX: begin
          take_digit(b, done);
          if (done) unit_alone(hex_acc);
        end
        ST_HIGH: begin
          if (b == CH_BSLASH) begin
            esc_state = ST_HIGH_BS;
          end else begin
            emit_code({5'b0, held_high});
            emit_byte(b);
            esc_state = ST_TEXT;
          end
        end
        ST_HIGH_BS: begin
          if (b == CH_U) begin
            esc_state = ST_HEX_LOW;
            digits = 2'd0;
            hex_acc = 16'h0000;
          end else if (simple_esc(b, v)) begin
            emit_code({5'b0, held_high});
            emit_byte(v);
            esc_state = ST_TEXT;
          end else begin
            fail_escape();
          end
        end
        ST_HEX_LOW: begin
          take_digit(b, done);
          if (done) begin
            if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
              emit_code(21'h10000 + {1'b0, held_high[9:0], hex_acc[9:0]});
              esc_state = ST_TEXT;
            end else begin
              emit_code({5'b0, held_high});
              unit_alone(hex_acc);
            end
          end
        end
        default: begin
          esc_state = ST_TEXT;
          if (b == CH_BSLASH) esc_state = ST_ESC;
          else emit_byte(b);
        end
      endcase
    end
    if (last) begin
      if (!err_flag) begin
        if (esc_state == ST_HIGH) emit_code({5'b0, held_high});
        else if (esc_state != ST_TEXT) err_flag = 1'b1;
      end
      if (err_flag) begin
        step_words.delete();
        step_words.push_back({8'h00, 1'b0, 1'b1, 1'b1});
      end else if (step_words.size() == 0) begin
        step_words.push_back({8'h00, 1'b0, 1'b0, 1'b1});
      end else begin
        w = step_words[step_words.size() - 1];
        w.last = 1'b1;
        step_words[step_words.size() - 1] = w;
      end
      esc_state = ST_TEXT;
      digits = 2'd0;
      hex_acc = 16'h0000;
      held_high = 16'h0000;
      err_flag = 1'b0;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    error_count++;
  endtask

  task automatic check_word();
    utf8_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected, out_byte", out_byte, 0);
    end else begin
      w = expected_words.pop_front();
      if (out_byte !== w.data) report_mismatch("out_byte", out_byte, w.data);
      if (has_byte !== w.has) report_mismatch("has_byte", has_byte, w.has);
      if (bad_escape !== w.bad) report_mismatch("bad_escape", bad_escape, w.bad);
      if (out_last !== w.last) report_mismatch("out_last", out_last, w.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_word(in_byte, in_last);
      if (!push || !full) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_word = pending_words.pop_front();
          push <= 1'b1;
          in_byte <= next_word.data;
          in_last <= next_word.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_word();
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic put_raw(input logic [7:0] b);
    build_bytes.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) build_bytes.push_back(s[i]);
  endtask

  task automatic end_string();
    raw_word_t w;
    for (int i = 0; i < build_bytes.size(); i++) begin
      w.data = build_bytes[i];
      w.last = (i == build_bytes.size() - 1);
      pending_words.push_back(w);
    end
    queued_bytes += build_bytes.size();
    build_bytes.delete();
  endtask

  task automatic put_hex_digit(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = CH_0 + {4'b0, n};
    else c = ($urandom_range(1) ? CH_LA : CH_UA) + {4'b0, n} - 8'd10;
    build_bytes.push_back(c);
  endtask

  task automatic put_unicode(input logic [15:0] v);
    put_raw(CH_BSLASH);
    put_raw(CH_U);
    for (int i = 3; i >= 0; i--) put_hex_digit(v[i*4 +: 4]);
  endtask

  function automatic logic [15:0] rand_unit();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h7F));
      1: v = 16'($urandom_range(16'h7FF, 16'h80));
      2: v = 16'($urandom_range(16'hD7FF, 16'h800));
      default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(16'hDBFF, 16'hD800));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'($urandom_range(16'hDFFF, 16'hDC00));
  endfunction

  function automatic logic [7:0] escape_letter(input int k);
    logic [7:0] c;
    case (k)
      0: c = CH_QUOTE;
      1: c = CH_BSLASH;
      2: c = CH_SLASH;
      3: c = CH_B;
      4: c = CH_LF;
      5: c = CH_N;
      6: c = CH_R;
      default: c = CH_T;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_letter();
    logic [7:0] c;
    logic [7:0] v;
    c = 8'($urandom_range(255));
    while (simple_esc(c, v) || c == CH_U) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (hex_nibble(c) >= 0) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic gen_token();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        c = 8'($urandom_range(255));
        if (c == CH_BSLASH) c = CH_BSLASH + 8'd1;
        put_raw(c);
      end
      4: begin
        put_raw(CH_BSLASH);
        put_raw(escape_letter($urandom_range(7)));
      end
      5: put_unicode(rand_unit());
      6: begin
        put_unicode(rand_high());
        put_unicode(rand_low());
      end
      7: put_unicode(rand_high());
      8: put_unicode(rand_low());
      default: begin
        put_unicode(rand_high());
        put_unicode($urandom_range(1) ? rand_unit() : rand_high());
      end
    endcase
  endtask

  task automatic gen_string();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) gen_token();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: begin
          put_raw(CH_BSLASH);
          put_raw(rand_bad_letter());
          gen_token();
        end
        1: begin
          put_raw(CH_BSLASH);
          put_raw(CH_U);
          repeat ($urandom_range(3)) put_hex_digit(4'($urandom_range(15)));
          put_raw(rand_non_hex());
          gen_token();
        end
        2: put_raw(CH_BSLASH);
        3: begin
          put_raw(CH_BSLASH);
          put_raw(CH_U);
          repeat ($urandom_range(3)) put_hex_digit(4'($urandom_range(15)));
        end
        default: begin
          put_unicode(rand_high());
          put_raw(CH_BSLASH);
          if ($urandom_range(1)) put_raw(rand_bad_letter());
        end
      endcase
    end
    end_string();
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || push || expected_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    put_raw(8'h00); put_raw(8'hFF); put_raw(8'h41); end_string();
    put_text("\\\"\\\\\\/\\b\\f\\n\\r\\t"); end_string();
    put_text("\\u0000\\u007f\\u0080\\u07FF\\u0800\\uffff"); end_string();
    put_text("\\uD800\\uDC00\\uDBFF\\uDFFF"); end_string();
    put_text("\\uD83D"); end_string();
    put_text("\\ud83dx"); end_string();
    put_text("\\uD83D\\n"); end_string();
    put_text("\\uD83D\\u0041"); end_string();
    put_text("\\uD800\\uDBFF\\uDC00"); end_string();
    put_text("\\uDC00z"); end_string();
    put_text("a\\qb"); end_string();
    put_text("\\u12G4x"); end_string();
    put_text("ab\\"); end_string();
    put_text("\\u00"); end_string();
    put_text("\\uD800\\"); end_string();
    put_text("\\uD800\\x"); end_string();
    put_text("\\"); end_string();
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      queued_bytes = 0;
      while (queued_bytes < PHASE_BYTES) gen_string();
      wait_drained();
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("words still expected", 0, expected_words.size());
    end
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
